FILE: rtl/core/rcv_pkg.sv
// Shared types, constants and register codes of the RGB 3x3 convolution block.
package rcv_pkg;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned ADDR_W        = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W         = ADDR_W + 1;
  localparam int unsigned WIDTH_BITS    = 11;
  localparam int unsigned HEIGHT_BITS   = 16;
  localparam int unsigned COEF_BITS     = 16;
  localparam int unsigned FRAC_BITS     = 10;
  localparam int unsigned COEF_ROW_BITS = 3 * COEF_BITS;
  localparam int unsigned CFG_DATA_W    = 48;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam int unsigned CH_BITS  = 8;
  localparam int unsigned PIX_BITS = 3 * CH_BITS;
  localparam int unsigned CH_MAX   = 255;
  localparam int unsigned PROD_W   = CH_BITS + COEF_BITS;
  localparam int unsigned ROW_W    = PROD_W + 2;
  localparam int unsigned SUM_W    = ROW_W + 2;

  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int unsigned JOB_CNT_W = JOB_PTR_W + 1;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = OUT_PTR_W + 1;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MIDDLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM  = 3'd4;

  // operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [2:0][COEF_ROW_BITS-1:0] coef_rows_t;

  typedef struct packed {
    logic               operation;
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red_out;
    logic [CH_BITS-1:0] green_out;
    logic [CH_BITS-1:0] blue_out;
    logic               last_of_item;
    logic               end_of_frame;
  } out_item_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_t;

  typedef struct packed {
    logic emit_a;   // centred output
    logic emit_b;   // row-end output, right column skipped
    logic top_ok;
    logic bot_ok;
    logic left_a;
    logic right_a;
    logic left_b;
    logic eof;
  } job_flags_t;

  typedef struct packed {
    pix_t [2:0][2:0] taps;  // [row][col]
    job_flags_t      flags;
  } job_t;

  typedef struct packed {
    logic [CNT_W-1:0]       width;
    logic [HEIGHT_BITS-1:0] height;
    logic                   clear;
  } frame_cfg_t;

  typedef enum logic [1:0] {
    S1_PIXEL,
    S1_DRAIN,
    S1_PRELOAD
  } s1_kind_e;

endpackage

FILE: rtl/core/rgb_conv3x3_fixed_point.sv
// Top level of the RGB 3x3 fixed-point convolution block.
//
// Input channel: a beat is taken when push_i is high and full_o is low. A beat
// is either a pixel (raster order) or a drain beat that flushes one pixel of
// the last row once the whole frame is in. Result channel: while empty_o is
// low the oldest result sits on out_o and leaves when pop_i is high.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i at once;
// writing width or height restarts the frame.
// Throughput: one input beat per cycle while full_o is low. The pixel that ends
// a row yields two results, which the back end issues from the same job before
// it pops it. After the last pixel of a frame full_o stays high for one cycle
// while column 0 of the line stores is fetched for the drain.
// A result passes line store read, kernel multiply, row sums, final sum and clamp.
// Stalls: the front end and the arithmetic back end are parted by a four-entry
// job queue and the results wait in an eight-entry queue; full_o rises once
// the job queue, with the beat in the front-end stage, is full, and during the
// drain fetch. Reset empties both queues and clears the counters; the line
// stores are not cleared and stale entries only feed skipped taps.
module rgb_conv3x3_fixed_point (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  rcv_pkg::in_item_t             in_i,
  output logic                          full_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output rcv_pkg::out_item_t            out_o,
  input  logic                          cfg_we_i,
  input  logic [rcv_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [rcv_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [rcv_pkg::WIDTH_BITS-1:0]  width_q, w_lim;
  logic [rcv_pkg::HEIGHT_BITS-1:0] height_q;
  rcv_pkg::coef_rows_t             coef_q;
  rcv_pkg::frame_cfg_t             frame_cfg;

  logic                          job_push, job_pop, job_vld;
  rcv_pkg::job_t                 job_in, job_out;
  logic [rcv_pkg::JOB_CNT_W-1:0] job_cnt;

  // zero width acts as one, anything past the line store depth is clipped
  always_comb begin
    if (width_q == '0) begin
      w_lim = rcv_pkg::WIDTH_BITS'(1);
    end else if (width_q > rcv_pkg::WIDTH_BITS'(rcv_pkg::MAX_WIDTH)) begin
      w_lim = rcv_pkg::WIDTH_BITS'(rcv_pkg::MAX_WIDTH);
    end else begin
      w_lim = width_q;
    end
  end

  assign frame_cfg.width  = rcv_pkg::CNT_W'(w_lim);
  assign frame_cfg.height = (height_q == '0) ? rcv_pkg::HEIGHT_BITS'(1) : height_q;
  assign frame_cfg.clear  = cfg_we_i && ((cfg_addr_i == rcv_pkg::CFG_IMAGE_WIDTH) ||
                                         (cfg_addr_i == rcv_pkg::CFG_IMAGE_HEIGHT));

  // reset kernel is 1.0 on the middle row's left tap and zero elsewhere
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= rcv_pkg::WIDTH_BITS'(rcv_pkg::MAX_WIDTH);
      height_q  <= rcv_pkg::HEIGHT_BITS'(1);
      coef_q[0] <= '0;
      coef_q[1] <= rcv_pkg::COEF_ROW_BITS'(1 << rcv_pkg::FRAC_BITS);
      coef_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rcv_pkg::CFG_IMAGE_WIDTH:  width_q   <= cfg_wdata_i[rcv_pkg::WIDTH_BITS-1:0];
        rcv_pkg::CFG_IMAGE_HEIGHT: height_q  <= cfg_wdata_i[rcv_pkg::HEIGHT_BITS-1:0];
        rcv_pkg::CFG_COEF_TOP:     coef_q[0] <= cfg_wdata_i[rcv_pkg::COEF_ROW_BITS-1:0];
        rcv_pkg::CFG_COEF_MIDDLE:  coef_q[1] <= cfg_wdata_i[rcv_pkg::COEF_ROW_BITS-1:0];
        rcv_pkg::CFG_COEF_BOTTOM:  coef_q[2] <= cfg_wdata_i[rcv_pkg::COEF_ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  rcv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_i       (in_i),
    .full_o     (full_o),
    .cfg_i      (frame_cfg),
    .job_cnt_i  (job_cnt),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  rcv_job_fifo u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .vld_o  (job_vld),
    .data_o (job_out),
    .cnt_o  (job_cnt)
  );

  rcv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_vld_i (job_vld),
    .job_i     (job_out),
    .job_pop_o (job_pop),
    .coef_i    (coef_q),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .out_o     (out_o)
  );

endmodule

FILE: rtl/core/rcv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/rcv_front.sv
// Front end: accepts beats, keeps frame counters, line stores and the 3x3 window, issues jobs.
module rcv_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  rcv_pkg::in_item_t            in_i,
  output logic                         full_o,
  input  rcv_pkg::frame_cfg_t          cfg_i,
  input  logic [rcv_pkg::JOB_CNT_W-1:0] job_cnt_i,
  output logic                         job_push_o,
  output rcv_pkg::job_t                job_o
);

  logic [rcv_pkg::ADDR_W-1:0]      col_q, col_d, drn_q, drn_d;
  logic [rcv_pkg::HEIGHT_BITS-1:0] row_q, row_d;
  logic                            pre_q, pre_d;

  logic                         s1_vld_q, s1_vld_d, s1_fwd_q, s1_fwd_d;
  rcv_pkg::s1_kind_e            s1_kind_q, s1_kind_d;
  rcv_pkg::pix_t                s1_px_q;
  logic [rcv_pkg::ADDR_W-1:0]   s1_addr_q, raddr;
  rcv_pkg::job_flags_t          s1_flags_q, s1_flags_d;

  rcv_pkg::line_t               ram_rdata, ram_wdata, wr_q, line;
  logic                         ram_we;
  rcv_pkg::pix_t [2:0][2:0]     win_q, win_d;
  rcv_pkg::pix_t [2:0]          new_col;

  logic                         acc, frame_in, row_end, drn_end;
  logic [rcv_pkg::CNT_W-1:0]    x_next, d_next;
  logic [rcv_pkg::JOB_CNT_W:0]  credit;

  assign credit = {1'b0, job_cnt_i} + (rcv_pkg::JOB_CNT_W + 1)'(s1_vld_q);
  assign full_o = pre_q | (credit >= (rcv_pkg::JOB_CNT_W + 1)'(rcv_pkg::JOB_DEPTH));
  assign acc    = push_i & ~full_o;

  assign x_next   = {1'b0, col_q} + rcv_pkg::CNT_W'(1);
  assign d_next   = {1'b0, drn_q} + rcv_pkg::CNT_W'(1);
  assign row_end  = (x_next == cfg_i.width);
  assign drn_end  = (d_next >= cfg_i.width);
  assign frame_in = (row_q >= cfg_i.height);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    drn_d      = drn_q;
    pre_d      = pre_q;
    s1_vld_d   = 1'b0;
    s1_kind_d  = rcv_pkg::S1_PIXEL;
    s1_flags_d = '0;
    raddr      = col_q;
    if (cfg_i.clear) begin
      col_d = '0;
      row_d = '0;
      drn_d = '0;
      pre_d = 1'b0;
    end else if (pre_q) begin
      // pull column 0 of the last two rows ahead of the first drain beat
      raddr     = '0;
      s1_vld_d  = 1'b1;
      s1_kind_d = rcv_pkg::S1_PRELOAD;
      pre_d     = 1'b0;
    end else if (acc) begin
      if (in_i.operation == rcv_pkg::OP_DRAIN) begin
        if (frame_in) begin
          raddr              = rcv_pkg::ADDR_W'(d_next);
          s1_vld_d           = 1'b1;
          s1_kind_d          = rcv_pkg::S1_DRAIN;
          s1_flags_d.emit_a  = 1'b1;
          s1_flags_d.top_ok  = (cfg_i.height >= rcv_pkg::HEIGHT_BITS'(2));
          s1_flags_d.left_a  = (drn_q != '0);
          s1_flags_d.right_a = (d_next < cfg_i.width);
          s1_flags_d.eof     = (d_next == cfg_i.width);
          if (drn_end) begin
            drn_d = '0;
            row_d = '0;
            col_d = '0;
          end else begin
            drn_d = d_next[rcv_pkg::ADDR_W-1:0];
          end
        end
      end else if (!frame_in) begin
        s1_vld_d           = 1'b1;
        s1_kind_d          = rcv_pkg::S1_PIXEL;
        s1_flags_d.emit_a  = (row_q != '0) && (col_q != '0);
        s1_flags_d.emit_b  = (row_q != '0) && row_end;
        s1_flags_d.top_ok  = (row_q >= rcv_pkg::HEIGHT_BITS'(2));
        s1_flags_d.bot_ok  = 1'b1;
        s1_flags_d.left_a  = (col_q >= rcv_pkg::ADDR_W'(2));
        s1_flags_d.right_a = 1'b1;
        s1_flags_d.left_b  = (cfg_i.width >= rcv_pkg::CNT_W'(2));
        if (row_end) begin
          col_d = '0;
          row_d = row_q + rcv_pkg::HEIGHT_BITS'(1);
          if (row_q + rcv_pkg::HEIGHT_BITS'(1) == cfg_i.height) begin
            pre_d = 1'b1;
          end
        end else begin
          col_d = x_next[rcv_pkg::ADDR_W-1:0];
        end
      end
    end
  end

  // back-to-back read of the entry that the previous beat writes
  assign s1_fwd_d = s1_vld_d && s1_vld_q && (s1_kind_q == rcv_pkg::S1_PIXEL)
                    && (s1_addr_q == raddr);

  rcv_ram #(
    .WIDTH ($bits(rcv_pkg::line_t)),
    .DEPTH (rcv_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign line      = s1_fwd_q ? wr_q : ram_rdata;
  assign ram_we    = s1_vld_q && (s1_kind_q == rcv_pkg::S1_PIXEL);
  assign ram_wdata = '{older: line.newer, newer: s1_px_q};

  always_comb begin
    new_col[0] = line.older;
    new_col[1] = line.newer;
    new_col[2] = (s1_kind_q == rcv_pkg::S1_PIXEL) ? s1_px_q : '0;
    win_d      = win_q;
    if (s1_vld_q) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
        win_d[r][2] = new_col[r];
      end
    end
  end

  assign job_o.taps  = win_d;
  assign job_o.flags = s1_flags_q;
  assign job_push_o  = s1_vld_q && (s1_kind_q != rcv_pkg::S1_PRELOAD)
                       && (s1_flags_q.emit_a || s1_flags_q.emit_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      drn_q     <= '0;
      pre_q     <= 1'b0;
      s1_vld_q  <= 1'b0;
      s1_fwd_q  <= 1'b0;
      s1_kind_q <= rcv_pkg::S1_PIXEL;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      drn_q     <= drn_d;
      pre_q     <= pre_d;
      s1_vld_q  <= s1_vld_d;
      s1_fwd_q  <= s1_fwd_d;
      s1_kind_q <= s1_kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_px_q    <= {in_i.red, in_i.green, in_i.blue};
    s1_addr_q  <= raddr;
    s1_flags_q <= s1_flags_d;
    wr_q       <= ram_wdata;
    win_q      <= win_d;
  end

endmodule

FILE: rtl/core/rcv_job_fifo.sv
// Short job queue between the front end and the arithmetic back end.
module rcv_job_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  rcv_pkg::job_t                 data_i,
  input  logic                          pop_i,
  output logic                          vld_o,
  output rcv_pkg::job_t                 data_o,
  output logic [rcv_pkg::JOB_CNT_W-1:0] cnt_o
);

  rcv_pkg::job_t                mem_q [rcv_pkg::JOB_DEPTH];
  logic [rcv_pkg::JOB_PTR_W-1:0] wptr_q, rptr_q;
  logic [rcv_pkg::JOB_CNT_W-1:0] cnt_q;
  logic                          do_pop;

  assign vld_o  = (cnt_q != '0);
  assign do_pop = pop_i & vld_o;
  assign data_o = mem_q[rptr_q];
  assign cnt_o  = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + rcv_pkg::JOB_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + rcv_pkg::JOB_PTR_W'(1);
      end
      cnt_q <= cnt_q + rcv_pkg::JOB_CNT_W'(push_i) - rcv_pkg::JOB_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/rcv_back.sv
// Back end: kernel multiply, sum, floor shift and clamp, plus the result queue.
module rcv_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_vld_i,
  input  rcv_pkg::job_t         job_i,
  output logic                  job_pop_o,
  input  rcv_pkg::coef_rows_t   coef_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output rcv_pkg::out_item_t    out_o
);

  logic sub_q, sub_d, issue, sel_b, last_e, eof_e;
  logic [rcv_pkg::OUT_CNT_W:0] inflight;

  rcv_pkg::pix_t [2:0][2:0] tap;
  logic [2:0] row_ok, col_ok;

  logic signed [rcv_pkg::PROD_W-1:0] prod_d [3][3][3];
  logic signed [rcv_pkg::PROD_W-1:0] p_prod_q [3][3][3];
  logic p_vld_q, p_last_q, p_eof_q;

  logic signed [rcv_pkg::ROW_W-1:0] s_row_d [3][3];
  logic signed [rcv_pkg::ROW_W-1:0] s_row_q [3][3];
  logic s_vld_q, s_last_q, s_eof_q;

  logic [rcv_pkg::CH_BITS-1:0] chan [3];
  rcv_pkg::out_item_t          res;

  rcv_pkg::out_item_t            omem_q [rcv_pkg::OUT_DEPTH];
  logic [rcv_pkg::OUT_PTR_W-1:0] owptr_q, orptr_q;
  logic [rcv_pkg::OUT_CNT_W-1:0] ocnt_q;
  logic                          opop;

  // room for every beat already in the pipe
  assign inflight = {1'b0, ocnt_q} + (rcv_pkg::OUT_CNT_W + 1)'(p_vld_q)
                    + (rcv_pkg::OUT_CNT_W + 1)'(s_vld_q);
  assign issue    = job_vld_i && (inflight < (rcv_pkg::OUT_CNT_W + 1)'(rcv_pkg::OUT_DEPTH));
  assign sel_b    = sub_q | ~job_i.flags.emit_a;
  assign last_e   = sel_b | ~job_i.flags.emit_b;
  assign eof_e    = ~sel_b & job_i.flags.eof;
  assign job_pop_o = issue & last_e;

  always_comb begin
    sub_d = sub_q;
    if (issue) begin
      sub_d = ~last_e;
    end
  end

  // row-end output reuses the window one column over
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tap[r][0] = sel_b ? job_i.taps[r][1] : job_i.taps[r][0];
      tap[r][1] = sel_b ? job_i.taps[r][2] : job_i.taps[r][1];
      tap[r][2] = sel_b ? '0 : job_i.taps[r][2];
    end
    row_ok = {job_i.flags.bot_ok, 1'b1, job_i.flags.top_ok};
    col_ok = {~sel_b & job_i.flags.right_a, 1'b1,
              sel_b ? job_i.flags.left_b : job_i.flags.left_a};
  end

  always_comb begin
    logic signed [rcv_pkg::PROD_W-1:0]    a;
    logic signed [rcv_pkg::PROD_W-1:0]    b;
    logic signed [rcv_pkg::COEF_BITS-1:0] k;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        k = coef_i[r][c*rcv_pkg::COEF_BITS +: rcv_pkg::COEF_BITS];
        b = rcv_pkg::PROD_W'(k);
        for (int ch = 0; ch < 3; ch++) begin
          a = rcv_pkg::PROD_W'(tap[r][c][(2-ch)*rcv_pkg::CH_BITS +: rcv_pkg::CH_BITS]);
          prod_d[ch][r][c] = (row_ok[r] && col_ok[c]) ? a * b : '0;
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        s_row_d[ch][r] = rcv_pkg::ROW_W'(p_prod_q[ch][r][0])
                       + rcv_pkg::ROW_W'(p_prod_q[ch][r][1])
                       + rcv_pkg::ROW_W'(p_prod_q[ch][r][2]);
      end
    end
  end

  always_comb begin
    logic signed [rcv_pkg::SUM_W-1:0] tot;
    logic signed [rcv_pkg::SUM_W-1:0] q;
    for (int ch = 0; ch < 3; ch++) begin
      tot = rcv_pkg::SUM_W'(s_row_q[ch][0]) + rcv_pkg::SUM_W'(s_row_q[ch][1])
          + rcv_pkg::SUM_W'(s_row_q[ch][2]);
      q   = tot >>> rcv_pkg::FRAC_BITS;
      if (q < 0) begin
        chan[ch] = '0;
      end else if (q > $signed(rcv_pkg::SUM_W'(rcv_pkg::CH_MAX))) begin
        chan[ch] = rcv_pkg::CH_BITS'(rcv_pkg::CH_MAX);
      end else begin
        chan[ch] = q[rcv_pkg::CH_BITS-1:0];
      end
    end
    res = '{red_out: chan[0], green_out: chan[1], blue_out: chan[2],
            last_of_item: s_last_q, end_of_frame: s_eof_q};
  end

  assign empty_o = (ocnt_q == '0);
  assign opop    = pop_i & ~empty_o;
  assign out_o   = omem_q[orptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= 1'b0;
      p_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      sub_q   <= sub_d;
      p_vld_q <= issue;
      s_vld_q <= p_vld_q;
      if (s_vld_q) begin
        owptr_q <= owptr_q + rcv_pkg::OUT_PTR_W'(1);
      end
      if (opop) begin
        orptr_q <= orptr_q + rcv_pkg::OUT_PTR_W'(1);
      end
      ocnt_q <= ocnt_q + rcv_pkg::OUT_CNT_W'(s_vld_q) - rcv_pkg::OUT_CNT_W'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    p_prod_q <= prod_d;
    p_last_q <= last_e;
    p_eof_q  <= eof_e;
    s_row_q  <= s_row_d;
    s_last_q <= p_last_q;
    s_eof_q  <= p_eof_q;
    if (s_vld_q) begin
      omem_q[owptr_q] <= res;
    end
  end

`ifndef SYNTH
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_vld_q && !opop) |-> (ocnt_q != rcv_pkg::OUT_CNT_W'(rcv_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= (rcv_pkg::OUT_CNT_W + 1)'(rcv_pkg::OUT_DEPTH))
    else $error("more results in flight than queue slots");

  a_second_half_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (job_vld_i && job_i.flags.emit_a && job_i.flags.emit_b))
    else $error("row-end half pending without its job at the head");
`endif

endmodule
